### src/x86ild_pkg.sv
// Shared types, constants and opcode tables for the x86-64 length decoder.
// No dependencies.
`default_nettype none
package x86ild_pkg;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       begin_req;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  length;
        logic [7:0]  opcode;
        logic        esc_map;
        logic        mrm_valid;
        logic [1:0]  mrm_mod;
        logic [2:0]  mrm_reg;
        logic [2:0]  mrm_rm;
        logic [2:0]  disp_size;
        logic signed [31:0] disp_value;
        logic [2:0]  flow_class;
        logic signed [31:0] branch_offset;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_PREFIX, PH_OPCODE, PH_ESC, PH_ESC3, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
    } t_phase;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INV   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    localparam logic [3:0] K_NONE  = 4'd0;
    localparam logic [3:0] K_BYTE  = 4'd1;
    localparam logic [3:0] K_WORD  = 4'd2;
    localparam logic [3:0] K_ZD    = 4'd3;
    localparam logic [3:0] K_QW    = 4'd4;
    localparam logic [3:0] K_ENTER = 4'd5;
    localparam logic [3:0] K_MOFFS = 4'd6;
    localparam logic [3:0] K_F6    = 4'd7;
    localparam logic [3:0] K_F7    = 4'd8;
    localparam logic [3:0] K_INV   = 4'd9;
    localparam logic [4:0] T_M     = 5'h10;

    localparam int QUEUE_DEPTH = 2;

    function automatic logic [4:0] one_byte_traits(input logic [7:0] b);
        logic [4:0] t;
        t = {1'b0, K_NONE};
        if (b < 8'h40) begin
            if (b == 8'h0F) t = {1'b0, K_NONE};
            else if (b[2:0] <= 3'd3) t = T_M | {1'b0, K_NONE};
            else if (b[2:0] == 3'd4) t = {1'b0, K_BYTE};
            else if (b[2:0] == 3'd5) t = {1'b0, K_ZD};
            else t = {1'b0, K_INV};
        end else if (b <= 8'h5F) t = {1'b0, K_NONE};
        else if (b <= 8'h62) t = {1'b0, K_INV};
        else if (b == 8'h63) t = T_M;
        else if (b == 8'h68 || b == 8'hA9 || b == 8'hE8 || b == 8'hE9) t = {1'b0, K_ZD};
        else if (b == 8'h69 || b == 8'h81 || b == 8'hC7) t = T_M | {1'b0, K_ZD};
        else if (b == 8'h6A || b == 8'hA8 || b == 8'hCD || b == 8'hEB) t = {1'b0, K_BYTE};
        else if (b == 8'h6B || b == 8'h80 || b == 8'h83 || b == 8'hC0 || b == 8'hC1
                 || b == 8'hC6) t = T_M | {1'b0, K_BYTE};
        else if (b >= 8'h70 && b <= 8'h7F) t = {1'b0, K_BYTE};
        else if (b >= 8'h84 && b <= 8'h8F) t = T_M;
        else if (b == 8'h82 || b == 8'h9A || b == 8'hC4 || b == 8'hC5 || b == 8'hCE)
            t = {1'b0, K_INV};
        else if (b >= 8'hD4 && b <= 8'hD6) t = {1'b0, K_INV};
        else if (b == 8'hEA) t = {1'b0, K_INV};
        else if (b >= 8'hA0 && b <= 8'hA3) t = {1'b0, K_MOFFS};
        else if (b >= 8'hB0 && b <= 8'hB7) t = {1'b0, K_BYTE};
        else if (b >= 8'hB8 && b <= 8'hBF) t = {1'b0, K_QW};
        else if (b == 8'hC2 || b == 8'hCA) t = {1'b0, K_WORD};
        else if (b == 8'hC8) t = {1'b0, K_ENTER};
        else if (b >= 8'hD0 && b <= 8'hD3) t = T_M;
        else if (b >= 8'hD8 && b <= 8'hDF) t = T_M;
        else if (b >= 8'hE0 && b <= 8'hE7) t = {1'b0, K_BYTE};
        else if (b == 8'hF6) t = T_M | {1'b0, K_F6};
        else if (b == 8'hF7) t = T_M | {1'b0, K_F7};
        else if (b == 8'hFE || b == 8'hFF) t = T_M;
        return t;
    endfunction

    function automatic logic [4:0] esc_map_traits(input logic [7:0] b);
        logic [4:0] t;
        t = T_M;
        if (b == 8'h04 || b == 8'h0A || b == 8'h0C || b == 8'h39 || b == 8'h3B)
            t = {1'b0, K_INV};
        else if ((b >= 8'h24 && b <= 8'h27) || (b >= 8'h3C && b <= 8'h3F))
            t = {1'b0, K_INV};
        else if (b == 8'h7A || b == 8'h7B || b == 8'hA6 || b == 8'hA7 || b == 8'hFF)
            t = {1'b0, K_INV};
        else if ((b >= 8'h05 && b <= 8'h09) || b == 8'h0B || b == 8'h0E) t = {1'b0, K_NONE};
        else if ((b >= 8'h30 && b <= 8'h37) || b == 8'h77) t = {1'b0, K_NONE};
        else if ((b >= 8'hA0 && b <= 8'hA2) || (b >= 8'hA8 && b <= 8'hAA)) t = {1'b0, K_NONE};
        else if (b >= 8'hC8 && b <= 8'hCF) t = {1'b0, K_NONE};
        else if (b >= 8'h80 && b <= 8'h8F) t = {1'b0, K_ZD};
        else if (b == 8'h0F || (b >= 8'h70 && b <= 8'h73) || b == 8'hA4 || b == 8'hAC)
            t = T_M | {1'b0, K_BYTE};
        else if (b == 8'hBA || b == 8'hC2 || (b >= 8'hC4 && b <= 8'hC6))
            t = T_M | {1'b0, K_BYTE};
        return t;
    endfunction

    function automatic logic is_prefix(input logic [7:0] b);
        return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
               b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == 8'h66 ||
               b == 8'h67;
    endfunction

    function automatic logic [2:0] classify(input logic [7:0] op, input logic two,
                                            input logic [2:0] reg_f);
        logic [2:0] c;
        c = 3'd0;
        if (two) c = (op >= 8'h80 && op <= 8'h8F) ? 3'd1 : 3'd0;
        else if (op == 8'hE8) c = 3'd2;
        else if (op == 8'hE9 || op == 8'hEB) c = 3'd3;
        else if (op == 8'hC2 || op == 8'hC3 || op == 8'hCA || op == 8'hCB) c = 3'd4;
        else if (op == 8'hCC || op == 8'hCD || op == 8'hCE) c = 3'd5;
        else if (op == 8'hFF) begin
            if (reg_f == 3'd2 || reg_f == 3'd3) c = 3'd6;
            else if (reg_f == 3'd4 || reg_f == 3'd5) c = 3'd7;
        end else if (op >= 8'h70 && op <= 8'h7F) c = 3'd1;
        return c;
    endfunction

endpackage
`default_nettype wire

### src/x86ild_front.sv
// Front end: byte-serial decode state machine, emits one raw record per instruction.
// Depends on x86ild_pkg.
`default_nettype none
module x86ild_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire x86ild_pkg::t_in_item  i_data,
    input  wire logic                  i_take,     // front may advance this cycle
    output logic                       o_rec_valid,
    output x86ild_pkg::t_out_item      o_rec
);
    import x86ild_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_bcnt, n_bcnt;
    logic [3:0]  r_pcnt, n_pcnt;
    logic        r_osz, n_osz, r_w, n_w, r_esc, n_esc;
    logic [7:0]  r_op, n_op, r_modrm, n_modrm;
    logic [4:0]  r_tr, n_tr;
    logic [3:0]  r_pend, n_pend, r_immb, n_immb;
    logic [31:0] r_disp, n_disp, r_imm, n_imm;
    logic [2:0]  r_dispb, n_dispb;

    // working copies after optional restart
    t_phase      c_phase;
    logic [4:0]  c_bcnt;
    logic [3:0]  c_pcnt, c_pend, c_immb;
    logic        c_osz, c_w, c_esc;
    logic [7:0]  c_op, c_modrm;
    logic [4:0]  c_tr;
    logic [31:0] c_disp, c_imm;
    logic [2:0]  c_dispb;

    logic [7:0]  b;
    logic        e;
    logic        done, fin, f_chk;
    logic [1:0]  err;
    logic [1:0]  idx;
    logic [3:0]  iidx;
    logic [3:0]  kind;
    logic [2:0]  reg_f;
    logic [3:0]  zd, isz;
    // step kinds after opcode/address
    typedef enum logic [1:0] {GO_NONE, GO_AFTER_OP, GO_AFTER_ADDR, GO_START_IMM} t_go;
    t_go go;

    always_comb begin
        b = i_data.code_byte;
        e = i_data.stream_end;
        c_phase = r_phase; c_bcnt = r_bcnt; c_pcnt = r_pcnt; c_osz = r_osz; c_w = r_w;
        c_esc = r_esc; c_op = r_op; c_modrm = r_modrm; c_tr = r_tr; c_pend = r_pend;
        c_immb = r_immb; c_disp = r_disp; c_imm = r_imm; c_dispb = r_dispb;
        if (i_data.begin_req) begin
            c_phase = PH_PREFIX; c_bcnt = '0; c_pcnt = '0; c_osz = 1'b0; c_w = 1'b0;
            c_esc = 1'b0; c_op = '0; c_modrm = '0; c_tr = '0; c_pend = '0;
            c_immb = '0; c_disp = '0; c_imm = '0; c_dispb = '0;
        end
        if (c_bcnt != 5'd31) c_bcnt = c_bcnt + 5'd1;

        n_phase = c_phase; n_bcnt = c_bcnt; n_pcnt = c_pcnt; n_osz = c_osz; n_w = c_w;
        n_esc = c_esc; n_op = c_op; n_modrm = c_modrm; n_tr = c_tr; n_pend = c_pend;
        n_immb = c_immb; n_disp = c_disp; n_imm = c_imm; n_dispb = c_dispb;
        done = 1'b0; fin = 1'b0; err = ST_OK; go = GO_NONE;
        idx = '0; iidx = '0;

        unique case (c_phase)
            PH_OPCODE, PH_PREFIX: begin
                if (c_phase == PH_PREFIX && is_prefix(b)) begin
                    if (b == 8'h66) n_osz = 1'b1;
                    n_pcnt = c_pcnt + 4'd1;
                    if (n_pcnt > 4'd14) begin done = 1'b1; err = ST_LONG; end
                    else if (e) begin done = 1'b1; err = ST_TRUNC; end
                end else if (c_phase == PH_PREFIX && b[7:4] == 4'h4) begin
                    n_w = b[3];
                    if (e) begin done = 1'b1; err = ST_TRUNC; end
                    else n_phase = PH_OPCODE;
                end else if (b == 8'h0F) begin
                    if (e) begin done = 1'b1; err = ST_TRUNC; end
                    else begin n_esc = 1'b1; n_phase = PH_ESC; end
                end else begin
                    n_op = b; n_tr = one_byte_traits(b); go = GO_AFTER_OP;
                end
            end
            PH_ESC: begin
                n_op = b;
                if (b == 8'h38 || b == 8'h3A) begin
                    if (e) begin done = 1'b1; err = ST_TRUNC; end
                    else n_phase = PH_ESC3;
                end else begin
                    n_tr = esc_map_traits(b); go = GO_AFTER_OP;
                end
            end
            PH_ESC3: begin
                n_tr = T_M | ((c_op == 8'h3A) ? {1'b0, K_BYTE} : {1'b0, K_NONE});
                go = GO_AFTER_OP;
            end
            PH_MODRM: begin
                n_modrm = b;
                n_dispb = '0;
                go = GO_AFTER_ADDR;
                if (b[7:6] != 2'd3) begin
                    if (b[7:6] == 2'd1) n_dispb = 3'd1;
                    else if (b[7:6] == 2'd2) n_dispb = 3'd4;
                    if (b[2:0] == 3'd4) begin
                        go = GO_NONE;
                        if (e) begin done = 1'b1; err = ST_TRUNC; end
                        else n_phase = PH_SIB;
                    end else if (b[7:6] == 2'd0 && b[2:0] == 3'd5) n_dispb = 3'd4;
                end
            end
            PH_SIB: begin
                if (c_modrm[7:6] == 2'd0 && b[2:0] == 3'd5) n_dispb = 3'd4;
                go = GO_AFTER_ADDR;
            end
            PH_DISP: begin
                idx = 2'(c_dispb[1:0] - c_pend[1:0]);
                n_disp = c_disp | ({24'd0, b} << {idx, 3'b000});
                n_pend = c_pend - 4'd1;
                if (n_pend == 4'd0) go = GO_START_IMM;
                else if (e) begin done = 1'b1; err = ST_TRUNC; end
            end
            PH_IMM: begin
                iidx = c_immb - c_pend;
                if (iidx < 4'd4) n_imm = c_imm | ({24'd0, b} << {iidx[1:0], 3'b000});
                n_pend = c_pend - 4'd1;
                if (n_pend == 4'd0) fin = 1'b1;
                else if (e) begin done = 1'b1; err = ST_TRUNC; end
            end
            default: ;
        endcase

        // follow-on steps shared by several phases
        if (go == GO_AFTER_OP) begin
            if (n_tr[3:0] == K_INV) begin done = 1'b1; err = ST_INV; end
            else if (n_tr[4]) begin
                if (e) begin done = 1'b1; err = ST_TRUNC; end
                else n_phase = PH_MODRM;
            end else go = GO_START_IMM;
        end else if (go == GO_AFTER_ADDR) begin
            if (n_dispb != 3'd0) begin
                if (e) begin done = 1'b1; err = ST_TRUNC; end
                else begin
                    n_pend = {1'b0, n_dispb}; n_disp = '0; n_phase = PH_DISP;
                end
                go = GO_NONE;
            end else go = GO_START_IMM;
        end
        kind = n_tr[3:0];
        reg_f = n_tr[4] ? n_modrm[5:3] : 3'd0;
        zd = (n_osz && !n_w) ? 4'd2 : 4'd4;
        unique case (kind)
            K_BYTE:  isz = 4'd1;
            K_WORD:  isz = 4'd2;
            K_ZD:    isz = zd;
            K_QW:    isz = n_w ? 4'd8 : (n_osz ? 4'd2 : 4'd4);
            K_ENTER: isz = 4'd3;
            K_MOFFS: isz = 4'd8;
            K_F6:    isz = (reg_f <= 3'd1) ? 4'd1 : 4'd0;
            K_F7:    isz = (reg_f <= 3'd1) ? zd : 4'd0;
            default: isz = 4'd0;
        endcase
        if (go == GO_START_IMM) begin
            if (isz == 4'd0) fin = 1'b1;
            else if (e) begin done = 1'b1; err = ST_TRUNC; end
            else begin
                n_immb = isz; n_pend = isz; n_imm = '0; n_phase = PH_IMM;
            end
        end
        f_chk = fin && !done;
        if (f_chk) begin
            done = 1'b1;
            if (n_bcnt > 5'd15) err = ST_LONG;
        end

        // raw record: back end finishes the field shaping
        o_rec = '0;
        o_rec.status = err;
        if (err == ST_OK) begin
            o_rec.length     = n_bcnt[3:0];
            o_rec.opcode     = n_op;
            o_rec.esc_map    = n_esc;
            o_rec.mrm_valid  = n_tr[4];
            o_rec.mrm_mod    = n_modrm[7:6];
            o_rec.mrm_reg    = n_modrm[5:3];
            o_rec.mrm_rm     = n_modrm[2:0];
            o_rec.disp_size  = n_dispb;
            o_rec.disp_value = n_disp;
            o_rec.flow_class = {1'b0, n_immb[2:0] == 3'd1, n_immb == 4'd4};
            o_rec.branch_offset = n_imm;
        end
        o_rec_valid = i_valid && i_take && done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX; r_bcnt <= '0; r_pcnt <= '0; r_osz <= 1'b0; r_w <= 1'b0;
            r_esc <= 1'b0; r_op <= '0; r_modrm <= '0; r_tr <= '0; r_pend <= '0;
            r_immb <= '0; r_disp <= '0; r_imm <= '0; r_dispb <= '0;
        end else if (i_valid && i_take) begin
            if (done) begin
                r_phase <= PH_PREFIX; r_bcnt <= '0; r_pcnt <= '0; r_osz <= 1'b0;
                r_w <= 1'b0; r_esc <= 1'b0; r_op <= '0; r_modrm <= '0; r_tr <= '0;
                r_pend <= '0; r_immb <= '0; r_disp <= '0; r_imm <= '0; r_dispb <= '0;
            end else begin
                r_phase <= n_phase; r_bcnt <= n_bcnt; r_pcnt <= n_pcnt; r_osz <= n_osz;
                r_w <= n_w; r_esc <= n_esc; r_op <= n_op; r_modrm <= n_modrm;
                r_tr <= n_tr; r_pend <= n_pend; r_immb <= n_immb; r_disp <= n_disp;
                r_imm <= n_imm; r_dispb <= n_dispb;
            end
        end
    end

    // an ok record that leaves always carries a nonzero length
    a_rec_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |-> (o_rec.status != ST_OK || o_rec.length != 4'd0))
        else $error("front: ok record with zero length");
    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= 4'd14)
        else $error("front: prefix count beyond limit");
    a_disp_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISP) |-> (r_dispb == 3'd1 || r_dispb == 3'd4))
        else $error("front: displacement phase without size");
endmodule
`default_nettype wire

### src/x86ild_back.sv
// Back end: queue of raw records, field shaping (sign extension, flow class) and output.
// Depends on x86ild_pkg.
`default_nettype none
module x86ild_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rec_valid,
    input  wire x86ild_pkg::t_out_item i_rec,
    output logic                       o_space,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output x86ild_pkg::t_out_item      o_data
);
    import x86ild_pkg::*;

    t_out_item  r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_out_item  h, s;
    logic [2:0] reg_f;
    logic [2:0] fc;
    logic       is8, is32;

    assign pop  = o_valid && !i_stall;
    assign push = i_rec_valid;
    assign o_space = (r_cnt != 2'(QUEUE_DEPTH)) || !i_stall;
    assign o_valid = r_cnt != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_rec;
    end

    // shape head entry into the final result
    always_comb begin
        h = r_q[r_rp];
        s = '0;
        s.status = h.status;
        is8  = h.flow_class[1];
        is32 = h.flow_class[0];
        if (h.status == ST_OK) begin
            reg_f = h.mrm_valid ? h.mrm_reg : 3'd0;
            fc = classify(h.opcode, h.esc_map, reg_f);
            s.length    = h.length;
            s.opcode    = h.opcode;
            s.esc_map   = h.esc_map;
            s.mrm_valid = h.mrm_valid;
            s.mrm_mod   = h.mrm_valid ? h.mrm_mod : 2'd0;
            s.mrm_reg   = reg_f;
            s.mrm_rm    = h.mrm_valid ? h.mrm_rm : 3'd0;
            s.disp_size = h.disp_size;
            if (h.disp_size == 3'd1) s.disp_value = {{24{h.disp_value[7]}}, h.disp_value[7:0]};
            else if (h.disp_size == 3'd4) s.disp_value = h.disp_value;
            s.flow_class = fc;
            if (fc >= 3'd1 && fc <= 3'd3) begin
                if (is8) s.branch_offset = {{24{h.branch_offset[7]}}, h.branch_offset[7:0]};
                else if (is32) s.branch_offset = h.branch_offset;
            end
        end else begin
            reg_f = '0; fc = '0;
        end
        o_data = s;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |-> r_cnt != 2'(QUEUE_DEPTH))
        else $error("back: queue overflow");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH))
        else $error("back: count out of range");
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.length == 4'd0)
        else $error("back: error result with length");
endmodule
`default_nettype wire

### src/x86_64_instruction_length_decoder.sv
// x86-64 instruction length decoder: one code byte accepted per cycle when not stalled.
// A result is written into the result queue on the byte that completes or faults it, and is shown from the queue head.
// Throughput: one byte per cycle while not stalled; a two-entry result queue decouples output stalls.
// Reset (synchronous, active low) returns the decode to the prefix phase, empties the queue.
// Depends on x86ild_pkg, x86ild_front, x86ild_back.
`default_nettype none
module x86_64_instruction_length_decoder (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire x86ild_pkg::t_in_item  i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output x86ild_pkg::t_out_item      o_data
);
    import x86ild_pkg::*;

    logic      space, rec_valid;
    t_out_item rec;

    assign o_stall = !space;

    x86ild_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .i_take(space), .o_rec_valid(rec_valid), .o_rec(rec)
    );

    x86ild_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rec_valid(rec_valid), .i_rec(rec),
        .o_space(space), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

### test/x86_64_instruction_length_decoder_tb.sv
// Testbench for the x86-64 instruction length decoder: byte streams with a
// predictor of the decode phases and a scoreboard of expected instruction results.
// Depends on x86ild_pkg and x86_64_instruction_length_decoder.
`default_nettype none
module x86_64_instruction_length_decoder_tb;
    import x86ild_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    int  errors;
    int  cycles;
    bit  hold_off_req;
    bit  no_idle;

    x86_64_instruction_length_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // Decode predictor and store of expected instruction results
    class decode_scoreboard;
        t_out_item pending_results[$];
        t_phase    ph;
        int unsigned nbytes, npfx, imm_n, disp_n, left;
        bit        osz, rexw, esc;
        logic [7:0] op, modrm;
        logic [4:0] traits;
        logic [31:0] disp_acc, imm_acc;

        function void clear_decode();
            ph = PH_PREFIX; nbytes = 0; npfx = 0; osz = 0; rexw = 0; op = 0;
            esc = 0; traits = 0; modrm = 0; left = 0; disp_acc = 0;
            imm_acc = 0; imm_n = 0; disp_n = 0;
        endfunction

        function void push_fail(logic [1:0] code);
            t_out_item r;
            r = '0;
            r.status = code;
            pending_results.push_back(r);
            clear_decode();
        endfunction

        function int unsigned imm_len(logic [3:0] kind, logic [2:0] rg);
            int unsigned zd;
            zd = (osz && !rexw) ? 2 : 4;
            case (kind)
                K_BYTE:  return 1;
                K_WORD:  return 2;
                K_ZD:    return zd;
                K_QW:    return rexw ? 8 : (osz ? 2 : 4);
                K_ENTER: return 3;
                K_MOFFS: return 8;
                K_F6:    return rg <= 1 ? 1 : 0;
                K_F7:    return rg <= 1 ? zd : 0;
                default: return 0;
            endcase
        endfunction

        function logic [2:0] flow_of(logic [2:0] rg);
            if (esc) return (op >= 8'h80 && op <= 8'h8F) ? 3'd1 : 3'd0;
            if (op == 8'hE8) return 3'd2;
            if (op == 8'hE9 || op == 8'hEB) return 3'd3;
            if (op == 8'hC2 || op == 8'hC3 || op == 8'hCA || op == 8'hCB) return 3'd4;
            if (op == 8'hCC || op == 8'hCD || op == 8'hCE) return 3'd5;
            if (op == 8'hFF) begin
                if (rg == 2 || rg == 3) return 3'd6;
                if (rg == 4 || rg == 5) return 3'd7;
                return 3'd0;
            end
            if (op >= 8'h70 && op <= 8'h7F) return 3'd1;
            return 3'd0;
        endfunction

        function void complete();
            t_out_item r;
            bit m;
            m = traits[4];
            if (nbytes > 15) begin
                push_fail(ST_LONG);
                return;
            end
            r = '0;
            r.status = ST_OK;
            r.length = nbytes[3:0];
            r.opcode = op;
            r.esc_map = esc;
            r.mrm_valid = m;
            r.mrm_mod = m ? modrm[7:6] : 2'd0;
            r.mrm_reg = m ? modrm[5:3] : 3'd0;
            r.mrm_rm = m ? modrm[2:0] : 3'd0;
            r.disp_size = disp_n[2:0];
            if (disp_n == 1) r.disp_value = {{24{disp_acc[7]}}, disp_acc[7:0]};
            else if (disp_n == 4) r.disp_value = disp_acc;
            r.flow_class = flow_of(r.mrm_reg);
            if (r.flow_class >= 1 && r.flow_class <= 3) begin
                if (imm_n == 1) r.branch_offset = {{24{imm_acc[7]}}, imm_acc[7:0]};
                else if (imm_n == 4) r.branch_offset = imm_acc;
            end
            pending_results.push_back(r);
            clear_decode();
        endfunction

        function void start_imm(bit fin);
            int unsigned n;
            n = imm_len(traits[3:0], traits[4] ? modrm[5:3] : 3'd0);
            if (n == 0) complete();
            else if (fin) push_fail(ST_TRUNC);
            else begin
                imm_n = n; left = n; imm_acc = 0; ph = PH_IMM;
            end
        endfunction

        function void after_opcode(bit fin);
            if (traits[3:0] == K_INV) push_fail(ST_INV);
            else if (traits[4]) begin
                if (fin) push_fail(ST_TRUNC);
                else ph = PH_MODRM;
            end else start_imm(fin);
        endfunction

        function void after_address(bit fin);
            if (disp_n != 0) begin
                if (fin) push_fail(ST_TRUNC);
                else begin
                    left = disp_n; disp_acc = 0; ph = PH_DISP;
                end
            end else start_imm(fin);
        endfunction

        function void take_opcode(logic [7:0] b, bit fin);
            if (b == 8'h0F) begin
                if (fin) push_fail(ST_TRUNC);
                else begin
                    esc = 1; ph = PH_ESC;
                end
            end else begin
                op = b;
                traits = one_byte_traits_tb(b);
                after_opcode(fin);
            end
        endfunction

        // Opcode table for single-byte opcodes
        function logic [4:0] one_byte_traits_tb(logic [7:0] b);
            if (b < 8'h40) begin
                if (b == 8'h0F) return {1'b0, K_NONE};
                if (b[2:0] <= 3) return T_M;
                if (b[2:0] == 4) return {1'b0, K_BYTE};
                if (b[2:0] == 5) return {1'b0, K_ZD};
                return {1'b0, K_INV};
            end
            if (b <= 8'h5F) return {1'b0, K_NONE};
            if (b <= 8'h62) return {1'b0, K_INV};
            if (b == 8'h63) return T_M;
            if (b == 8'h68 || b == 8'hA9 || b == 8'hE8 || b == 8'hE9) return {1'b0, K_ZD};
            if (b == 8'h69 || b == 8'h81 || b == 8'hC7) return T_M | {1'b0, K_ZD};
            if (b == 8'h6A || b == 8'hA8 || b == 8'hCD || b == 8'hEB) return {1'b0, K_BYTE};
            if (b == 8'h6B || b == 8'h80 || b == 8'h83 || b == 8'hC0 || b == 8'hC1 ||
                b == 8'hC6) return T_M | {1'b0, K_BYTE};
            if (b >= 8'h70 && b <= 8'h7F) return {1'b0, K_BYTE};
            if (b >= 8'h84 && b <= 8'h8F) return T_M;
            if (b == 8'h82 || b == 8'h9A || b == 8'hC4 || b == 8'hC5 || b == 8'hCE)
                return {1'b0, K_INV};
            if (b >= 8'hD4 && b <= 8'hD6) return {1'b0, K_INV};
            if (b == 8'hEA) return {1'b0, K_INV};
            if (b >= 8'hA0 && b <= 8'hA3) return {1'b0, K_MOFFS};
            if (b >= 8'hB0 && b <= 8'hB7) return {1'b0, K_BYTE};
            if (b >= 8'hB8 && b <= 8'hBF) return {1'b0, K_QW};
            if (b == 8'hC2 || b == 8'hCA) return {1'b0, K_WORD};
            if (b == 8'hC8) return {1'b0, K_ENTER};
            if (b >= 8'hD0 && b <= 8'hD3) return T_M;
            if (b >= 8'hD8 && b <= 8'hDF) return T_M;
            if (b >= 8'hE0 && b <= 8'hE7) return {1'b0, K_BYTE};
            if (b == 8'hF6) return T_M | {1'b0, K_F6};
            if (b == 8'hF7) return T_M | {1'b0, K_F7};
            if (b == 8'hFE || b == 8'hFF) return T_M;
            return {1'b0, K_NONE};
        endfunction

        // Opcode table for the 0x0F map
        function logic [4:0] esc_traits(logic [7:0] b);
            if (b == 8'h04 || b == 8'h0A || b == 8'h0C || b == 8'h39 || b == 8'h3B)
                return {1'b0, K_INV};
            if ((b >= 8'h24 && b <= 8'h27) || (b >= 8'h3C && b <= 8'h3F))
                return {1'b0, K_INV};
            if (b == 8'h7A || b == 8'h7B || b == 8'hA6 || b == 8'hA7 || b == 8'hFF)
                return {1'b0, K_INV};
            if ((b >= 8'h05 && b <= 8'h09) || b == 8'h0B || b == 8'h0E) return {1'b0, K_NONE};
            if ((b >= 8'h30 && b <= 8'h37) || b == 8'h77) return {1'b0, K_NONE};
            if ((b >= 8'hA0 && b <= 8'hA2) || (b >= 8'hA8 && b <= 8'hAA)) return {1'b0, K_NONE};
            if (b >= 8'hC8 && b <= 8'hCF) return {1'b0, K_NONE};
            if (b >= 8'h80 && b <= 8'h8F) return {1'b0, K_ZD};
            if (b == 8'h0F || (b >= 8'h70 && b <= 8'h73) || b == 8'hA4 || b == 8'hAC)
                return T_M | {1'b0, K_BYTE};
            if (b == 8'hBA || b == 8'hC2 || (b >= 8'hC4 && b <= 8'hC6))
                return T_M | {1'b0, K_BYTE};
            return T_M;
        endfunction

        function bit legacy_prefix(logic [7:0] b);
            return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
                   b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == 8'h66 ||
                   b == 8'h67;
        endfunction

        // Advance the decode by one accepted byte
        function void note_byte(t_in_item it);
            logic [7:0] b;
            bit fin;
            int unsigned idx;
            b = it.code_byte;
            fin = it.stream_end;
            if (it.begin_req) clear_decode();
            if (nbytes < 31) nbytes++;
            case (ph)
                PH_OPCODE: take_opcode(b, fin);
                PH_ESC: begin
                    op = b;
                    if (b == 8'h38 || b == 8'h3A) begin
                        if (fin) push_fail(ST_TRUNC);
                        else ph = PH_ESC3;
                    end else begin
                        traits = esc_traits(b);
                        after_opcode(fin);
                    end
                end
                PH_ESC3: begin
                    traits = T_M | ((op == 8'h3A) ? {1'b0, K_BYTE} : {1'b0, K_NONE});
                    after_opcode(fin);
                end
                PH_MODRM: begin
                    modrm = b;
                    disp_n = 0;
                    if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
                        if (b[7:6] == 2'd1) disp_n = 1;
                        else if (b[7:6] == 2'd2) disp_n = 4;
                        if (fin) push_fail(ST_TRUNC);
                        else ph = PH_SIB;
                    end else begin
                        if (b[7:6] == 2'd0 && b[2:0] == 3'd5) disp_n = 4;
                        if (b[7:6] == 2'd1) disp_n = 1;
                        else if (b[7:6] == 2'd2) disp_n = 4;
                        after_address(fin);
                    end
                end
                PH_SIB: begin
                    if (modrm[7:6] == 2'd0 && b[2:0] == 3'd5) disp_n = 4;
                    after_address(fin);
                end
                PH_DISP: begin
                    idx = (disp_n - left) & 3;
                    disp_acc = disp_acc | (32'(b) << (8 * idx));
                    left = (left - 1) & 15;
                    if (left == 0) start_imm(fin);
                    else if (fin) push_fail(ST_TRUNC);
                end
                PH_IMM: begin
                    idx = (imm_n - left) & 15;
                    if (idx < 4) imm_acc = imm_acc | (32'(b) << (8 * idx));
                    left = (left - 1) & 15;
                    if (left == 0) complete();
                    else if (fin) push_fail(ST_TRUNC);
                end
                default: begin
                    if (legacy_prefix(b)) begin
                        if (b == 8'h66) osz = 1;
                        npfx++;
                        if (npfx > 14) push_fail(ST_LONG);
                        else if (fin) push_fail(ST_TRUNC);
                    end else if (b[7:4] == 4'h4) begin
                        rexw = b[3];
                        if (fin) push_fail(ST_TRUNC);
                        else ph = PH_OPCODE;
                    end else take_opcode(b, fin);
                end
            endcase
        endfunction

        // Compare one delivered result against the oldest expectation
        function int check_result(t_out_item got);
            t_out_item w;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                return 1;
            end
            w = pending_results.pop_front();
            if (got !== w) begin
                $display("%0t: mismatch expected %p", $time, w);
                $display("%0t:          actual   %p", $time, got);
                return 1;
            end
            return 0;
        endfunction
    endclass

    decode_scoreboard sb;
    t_in_item byte_stream[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Queue helpers for building instruction streams
    task automatic add_byte(logic [7:0] b, bit st = 0, bit fin = 0);
        t_in_item it;
        it.code_byte = b;
        it.begin_req = st;
        it.stream_end = fin;
        byte_stream.push_back(it);
    endtask

    task automatic add_rand_bytes(int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    // Instruction-like byte sequence with random content
    task automatic add_instruction();
        int k;
        logic [7:0] m;
        k = $urandom_range(0, 9);
        if (k < 3) begin
            repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? 8'h66 : 8'hF3);
        end
        if ($urandom_range(0, 3) == 0) add_byte(8'h40 | 8'($urandom_range(0, 15)));
        case ($urandom_range(0, 7))
            0: add_byte(8'h0F);
            1: begin
                add_byte(8'h0F);
                add_byte($urandom_range(0, 1) ? 8'h38 : 8'h3A);
            end
            default: ;
        endcase
        add_byte(8'($urandom));
        m = 8'($urandom);
        add_byte(m);
        add_rand_bytes($urandom_range(0, 9));
    endtask

    // Sender: offers bytes at the falling edge, holds them until taken
    task automatic send_all();
        t_in_item it;
        while (byte_stream.size() > 0) begin
            it = byte_stream.pop_front();
            @(negedge i_clk);
            while (!no_idle && $urandom_range(0, 99) < 22) begin
                i_valid <= 0;
                @(negedge i_clk);
            end
            i_valid <= 1;
            i_data <= it;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver stall pattern, with a long hold-off on request
    initial begin
        int hold;
        i_stall = 1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                hold = 60;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1;
            end else i_stall <= !no_idle && ($urandom_range(0, 99) < 22);
        end
    end

    // Byte and result monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_byte(i_data);
            if (o_valid && !i_stall) errors += sb.check_result(o_data);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("x86_64_instruction_length_decoder test failed");
            $finish;
        end
    end

    initial begin
        int n;
        sb = new();
        sb.clear_decode();
        errors = 0;
        cycles = 0;
        hold_off_req = 0;
        no_idle = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: opcode classes, prefixes, errors, restart
        add_byte(8'h90, 1);
        add_byte(8'hE8); add_rand_bytes(4);
        add_byte(8'hEB); add_byte(8'h80);
        add_byte(8'h66); add_byte(8'hE9); add_byte(8'hFF); add_byte(8'h7F);
        add_byte(8'h0F); add_byte(8'h84); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'hFF); add_byte(8'h14); add_byte(8'h25); add_rand_bytes(4);
        add_byte(8'hFF); add_byte(8'h64); add_byte(8'h24); add_byte(8'h80);
        add_byte(8'h48); add_byte(8'hB8); add_rand_bytes(8);
        add_byte(8'hF7); add_byte(8'h05); add_rand_bytes(8);
        add_byte(8'hC8); add_rand_bytes(3);
        add_byte(8'hA1); add_rand_bytes(8);
        add_byte(8'h0F); add_byte(8'h3A); add_byte(8'h0F); add_byte(8'hC0); add_byte(8'h01);
        add_byte(8'h06);
        add_byte(8'h0F); add_byte(8'h04);
        add_byte(8'h48); add_byte(8'h66); add_byte(8'hC3);
        repeat (15) add_byte(8'hF0);
        repeat (14) add_byte(8'h26);
        add_byte(8'h48); add_byte(8'h81); add_byte(8'h84); add_rand_bytes(9);
        add_byte(8'h05); add_byte(8'h01);
        add_byte(8'h90, 1);
        add_byte(8'h0F, 0, 1);
        add_byte(8'hE8); add_byte(8'h00, 0, 1);
        add_byte(8'hC3, 0, 1);
        send_all();
        drain();

        // Long receiver hold-off while the sender keeps offering
        hold_off_req = 1;
        repeat (20) add_instruction();
        send_all();
        drain();

        // Random instruction streams, some noise, restarts and ends
        n = 0;
        while (n < 350) begin
            if ($urandom_range(0, 9) < 8) add_instruction();
            else add_rand_bytes($urandom_range(1, 6));
            if ($urandom_range(0, 15) == 0) add_byte(8'($urandom), 1, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 15) == 0) add_byte(8'($urandom), 0, 1);
            n += byte_stream.size();
            no_idle = (n > 100 && n < 200);
            send_all();
        end
        no_idle = 0;
        drain();

        if (errors == 0 && sb.pending_results.size() == 0) begin
            $display("x86_64_instruction_length_decoder test passed");
        end else begin
            $display("x86_64_instruction_length_decoder test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
src/x86ild_pkg.sv
src/x86ild_front.sv
src/x86ild_back.sv
src/x86_64_instruction_length_decoder.sv
test/x86_64_instruction_length_decoder_tb.sv
